// ----- sv/thyristor_phase_soft_start_assert.svh -----
// assertion macros for the thyristor phase soft starter
`ifndef THYRISTOR_PHASE_SOFT_START_ASSERT_SVH
`define THYRISTOR_PHASE_SOFT_START_ASSERT_SVH

`ifndef SYNTHESIS
`define TPSS_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tpss assertion failed");
`define TPSS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tpss assertion failed");
`else
`define TPSS_ASSERT_SAME(label, clk, rst, ante, cons)
`define TPSS_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ----- sv/tpss_pkg.sv -----
// types and constants of the thyristor phase soft starter
package tpss_pkg;

   localparam int unsigned ANGLE_W     = 10;
   localparam int unsigned PULSE_W     = 8;
   localparam int unsigned DECIM_W     = 8;
   localparam int unsigned LEVEL_W     = 24;
   localparam int unsigned CSR_IDX_W   = 3;
   localparam int unsigned CSR_DATA_W  = 24;
   localparam int unsigned REQ_FIELD_W = 27;
   localparam int unsigned REQ_DATA_W  = 32;
   localparam int unsigned RSP_FIELD_W = 13;
   localparam int unsigned RSP_DATA_W  = 16;

   localparam logic [ANGLE_W-1:0] INITIAL_ANGLE_RST   = 10'd270;
   localparam logic [ANGLE_W-1:0] MIN_ANGLE_RST       = 10'd110;
   localparam logic [PULSE_W-1:0] PULSE_TICKS_RST     = 8'd25;
   localparam logic [DECIM_W-1:0] DECIMATION_RST      = 8'd20;
   localparam logic [LEVEL_W-1:0] START_THRESHOLD_RST = 24'd8388608;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_INITIAL_ANGLE   = 3'd0,
      CSR_MIN_ANGLE       = 3'd1,
      CSR_PULSE_TICKS     = 3'd2,
      CSR_DECIMATION      = 3'd3,
      CSR_START_THRESHOLD = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [ANGLE_W-1:0] angle_now;
      logic               fully_on;
      logic               lower_gate;
      logic               upper_gate;
   } rsp_type;

endpackage

// ----- sv/thyristor_phase_soft_start.sv -----
// thyristor phase soft starter: two firing channels, angle ramp and latch-on
// each accepted req transaction is registered into the output buffer that drives rsp_tvalid
// throughput of one transaction per cycle while req_tready is high; a two-entry output buffer absorbs a stall
// req_tready is low only while both output entries are full
// synchronous active-high reset restores register defaults, angle 270, all channels idle
// initial_angle writes are accepted but the fire angle only reloads to 270 at reset
`include "thyristor_phase_soft_start_assert.svh"

module thyristor_phase_soft_start #(
   parameter int unsigned COUNTER_BITS = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // pos_zero_cross, neg_zero_cross, slow_tick, bus_level[23:0], zero fill
   input  logic [tpss_pkg::REQ_DATA_W-1:0]       req_tdata,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // upper_gate, lower_gate, fully_on, angle_now[9:0], zero fill
   output logic [tpss_pkg::RSP_DATA_W-1:0]       rsp_tdata,
   input  logic                                  csr_we,
   input  logic [tpss_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [tpss_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   localparam logic [COUNTER_BITS-1:0] CNT_MAX = {COUNTER_BITS{1'b1}};

   logic [tpss_pkg::ANGLE_W-1:0] min_angle_ff;
   logic [tpss_pkg::PULSE_W-1:0] pulse_ticks_ff;
   logic [tpss_pkg::DECIM_W-1:0] decimation_ff;
   logic [tpss_pkg::LEVEL_W-1:0] start_threshold_ff;

   logic [COUNTER_BITS-1:0] angle_cnt_ff [2];
   logic [COUNTER_BITS-1:0] angle_cnt_in [2];
   logic [COUNTER_BITS-1:0] pulse_cnt_ff [2];
   logic [COUNTER_BITS-1:0] pulse_cnt_in [2];
   logic [1:0]              armed_ff, armed_in;
   logic [1:0]              pulsing_ff, pulsing_in;
   logic [tpss_pkg::ANGLE_W-1:0] gate_angle_ff, gate_angle_in;
   logic [tpss_pkg::DECIM_W-1:0] decim_cnt_ff, decim_cnt_in;
   logic                         latched_ff, latched_in;

   logic                   out_valid_ff, skid_valid_ff;
   tpss_pkg::rsp_type      out_ff, skid_ff;
   tpss_pkg::rsp_type      result;

   logic                         req_accept, rsp_pop;
   logic [1:0]                   zero_cross;
   logic                         slow_tick;
   logic [tpss_pkg::LEVEL_W-1:0] bus_level;
   logic [tpss_pkg::DECIM_W:0]   decim_next;

   assign zero_cross = req_tdata[1:0];
   assign slow_tick  = req_tdata[2];
   assign bus_level  = req_tdata[tpss_pkg::REQ_FIELD_W-1:3];

   assign req_tready = !skid_valid_ff;
   assign req_accept = req_tvalid && req_tready;
   assign rsp_pop    = out_valid_ff && rsp_tready;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(tpss_pkg::RSP_DATA_W - tpss_pkg::RSP_FIELD_W){1'b0}}, out_ff};

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         min_angle_ff       <= tpss_pkg::MIN_ANGLE_RST;
         pulse_ticks_ff     <= tpss_pkg::PULSE_TICKS_RST;
         decimation_ff      <= tpss_pkg::DECIMATION_RST;
         start_threshold_ff <= tpss_pkg::START_THRESHOLD_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            tpss_pkg::CSR_INITIAL_ANGLE: begin
            end
            tpss_pkg::CSR_MIN_ANGLE: begin
               min_angle_ff <= csr_wdata[tpss_pkg::ANGLE_W-1:0];
            end
            tpss_pkg::CSR_PULSE_TICKS: begin
               pulse_ticks_ff <= csr_wdata[tpss_pkg::PULSE_W-1:0];
            end
            tpss_pkg::CSR_DECIMATION: begin
               decimation_ff <= csr_wdata[tpss_pkg::DECIM_W-1:0];
            end
            tpss_pkg::CSR_START_THRESHOLD: begin
               start_threshold_ff <= csr_wdata;
            end
            default: begin
            end
         endcase
      end
   end

   // per-transaction next state
   always_comb begin
      for (int ch = 0; ch < 2; ch++) begin
         angle_cnt_in[ch] = zero_cross[ch] ? '0 : angle_cnt_ff[ch];
         armed_in[ch]     = zero_cross[ch] | armed_ff[ch];
         pulse_cnt_in[ch] = pulse_cnt_ff[ch];
         pulsing_in[ch]   = pulsing_ff[ch];
         if (!latched_ff) begin
            angle_cnt_in[ch] = (angle_cnt_in[ch] == CNT_MAX) ? CNT_MAX
                                                             : angle_cnt_in[ch] + 1'b1;
            pulse_cnt_in[ch] = (pulse_cnt_in[ch] == CNT_MAX) ? CNT_MAX
                                                             : pulse_cnt_in[ch] + 1'b1;
            if (armed_in[ch] &&
                angle_cnt_in[ch] > COUNTER_BITS'(gate_angle_ff)) begin
               armed_in[ch]     = 1'b0;
               pulsing_in[ch]   = 1'b1;
               pulse_cnt_in[ch] = '0;
            end
            if (pulsing_in[ch] && pulse_cnt_in[ch] > COUNTER_BITS'(pulse_ticks_ff)) begin
               pulsing_in[ch] = 1'b0;
            end
         end
      end

      latched_in    = latched_ff;
      decim_cnt_in  = decim_cnt_ff;
      gate_angle_in = gate_angle_ff;
      decim_next    = {1'b0, decim_cnt_ff} + 1'b1;
      if (slow_tick) begin
         priority if (!latched_ff && bus_level > start_threshold_ff) begin
            latched_in = 1'b1;
         end else if (!latched_ff) begin
            if (decimation_ff != '0 && decim_next >= {1'b0, decimation_ff}) begin
               decim_cnt_in = '0;
            end else begin
               decim_cnt_in = decim_next[tpss_pkg::DECIM_W-1:0];
            end
            if (decim_cnt_in == '0 && gate_angle_ff > min_angle_ff) begin
               gate_angle_in = gate_angle_ff - 1'b1;
            end
         end else begin
            latched_in = latched_ff;
         end
      end

      result.upper_gate = latched_in | pulsing_in[0];
      result.lower_gate = latched_in | pulsing_in[1];
      result.fully_on   = latched_in;
      result.angle_now  = gate_angle_in;
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int ch = 0; ch < 2; ch++) begin
            angle_cnt_ff[ch] <= '0;
            pulse_cnt_ff[ch] <= '0;
         end
         armed_ff      <= '0;
         pulsing_ff    <= '0;
         gate_angle_ff <= tpss_pkg::INITIAL_ANGLE_RST;
         decim_cnt_ff  <= '0;
         latched_ff    <= 1'b0;
      end else if (req_accept) begin
         for (int ch = 0; ch < 2; ch++) begin
            angle_cnt_ff[ch] <= angle_cnt_in[ch];
            pulse_cnt_ff[ch] <= pulse_cnt_in[ch];
         end
         armed_ff      <= armed_in;
         pulsing_ff    <= pulsing_in;
         gate_angle_ff <= gate_angle_in;
         decim_cnt_ff  <= decim_cnt_in;
         latched_ff    <= latched_in;
      end
   end

   // two-entry output buffer
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (req_accept) begin
            if (!out_valid_ff || rsp_pop) begin
               out_valid_ff <= 1'b1;
            end else begin
               skid_valid_ff <= 1'b1;
            end
         end else if (rsp_pop) begin
            out_valid_ff  <= skid_valid_ff;
            skid_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         if (!out_valid_ff || rsp_pop) begin
            out_ff <= result;
         end else begin
            skid_ff <= result;
         end
      end else if (rsp_pop) begin
         out_ff <= skid_ff;
      end
   end

   `TPSS_ASSERT_SAME(a_skid_behind_out, clock, reset, skid_valid_ff, out_valid_ff)
   `TPSS_ASSERT_NEXT(a_latch_holds, clock, reset, latched_ff, latched_ff)
   `TPSS_ASSERT_NEXT(a_angle_never_rises, clock, reset, 1'b1,
                     gate_angle_ff <= $past(gate_angle_ff))

endmodule

// ----- tb/thyristor_phase_soft_start_tb.sv -----
// self-checking testbench for the thyristor phase soft starter: gate firing, angle ramp, latch-on
module thyristor_phase_soft_start_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned CNT_W        = 16;
   localparam int unsigned CYCLE_LIMIT  = 600000;
   localparam int unsigned STALL_CYCLES = 200;
   localparam int unsigned PHASE_TICKS  = 390;
   localparam logic [tpss_pkg::CSR_IDX_W-1:0] CSR_SPARE_FIRST = 3'd5;
   localparam logic [tpss_pkg::CSR_IDX_W-1:0] CSR_SPARE_LAST  = 3'd7;
   localparam logic [tpss_pkg::LEVEL_W-1:0]   LEVEL_MAX       = 24'hFFFFFF;

   typedef struct packed {
      logic [tpss_pkg::LEVEL_W-1:0] bus_level;
      logic                         slow_tick;
      logic                         neg_zero_cross;
      logic                         pos_zero_cross;
   } tick_type;

   typedef struct {
      logic [tpss_pkg::ANGLE_W-1:0] initial_angle;
      logic [tpss_pkg::ANGLE_W-1:0] min_angle;
      logic [tpss_pkg::PULSE_W-1:0] pulse_ticks;
      logic [tpss_pkg::DECIM_W-1:0] decimation;
      logic [tpss_pkg::LEVEL_W-1:0] start_threshold;
   } settings_type;

   typedef struct {
      bit             armed;
      bit             pulsing;
      bit [CNT_W-1:0] angle_cnt;
      bit [CNT_W-1:0] pulse_cnt;
   } channel_type;

   logic                            clock      = 1'b0;
   logic                            reset      = 1'b1;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [tpss_pkg::REQ_DATA_W-1:0] req_tdata  = '0;
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic [tpss_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic                            csr_we     = 1'b0;
   logic [tpss_pkg::CSR_IDX_W-1:0]  csr_index  = '0;
   logic [tpss_pkg::CSR_DATA_W-1:0] csr_wdata  = '0;

   // predicted state of the starter
   settings_type                 cfg;
   channel_type                  upper_ch;
   channel_type                  lower_ch;
   logic [tpss_pkg::ANGLE_W-1:0] gate_angle;
   logic [tpss_pkg::DECIM_W-1:0] decim_count;
   bit                           latched;
   bit                           started;

   tpss_pkg::rsp_type gate_drive_q[$];
   tpss_pkg::rsp_type got_drive;
   tpss_pkg::rsp_type want_drive;
   int unsigned mismatches    = 0;
   int unsigned drives_checked = 0;
   int unsigned ticks_sent    = 0;
   int unsigned pulses_fired  = 0;
   int unsigned cycles        = 0;
   int unsigned rsp_hold      = 0;
   bit          req_steady    = 1'b0;
   bit          rsp_steady    = 1'b0;
   bit          pos_next      = 1'b1;

   thyristor_phase_soft_start #(
      .COUNTER_BITS(CNT_W)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   function automatic tick_type make_tick(input bit pos, input bit neg, input bit slow,
                                          input logic [tpss_pkg::LEVEL_W-1:0] bus);
      tick_type t;
      t.pos_zero_cross = pos;
      t.neg_zero_cross = neg;
      t.slow_tick      = slow;
      t.bus_level      = bus;
      return t;
   endfunction

   function automatic channel_type step_channel(input channel_type c);
      channel_type n;
      n = c;
      if (n.angle_cnt != '1) n.angle_cnt = n.angle_cnt + 1'b1;
      if (n.pulse_cnt != '1) n.pulse_cnt = n.pulse_cnt + 1'b1;
      if (n.armed && n.angle_cnt > gate_angle) begin
         n.armed     = 1'b0;
         n.pulsing   = 1'b1;
         n.pulse_cnt = '0;
         pulses_fired++;
      end
      if (n.pulsing && n.pulse_cnt > cfg.pulse_ticks) n.pulsing = 1'b0;
      return n;
   endfunction

   // one pwm tick of the starter, returns the gate drive seen after it
   function automatic tpss_pkg::rsp_type fire_tick(input tick_type t);
      tpss_pkg::rsp_type          r;
      logic [tpss_pkg::DECIM_W:0] next_count;
      if (t.pos_zero_cross) begin
         upper_ch.armed     = 1'b1;
         upper_ch.angle_cnt = '0;
      end
      if (t.neg_zero_cross) begin
         lower_ch.armed     = 1'b1;
         lower_ch.angle_cnt = '0;
      end
      if (!latched) begin
         upper_ch = step_channel(upper_ch);
         lower_ch = step_channel(lower_ch);
      end
      if (t.slow_tick) begin
         if (!started && t.bus_level > cfg.start_threshold) begin
            latched = 1'b1;
            started = 1'b1;
         end else if (!latched) begin
            next_count = {1'b0, decim_count} + 1'b1;
            if (cfg.decimation != '0 && next_count >= cfg.decimation) next_count = '0;
            decim_count = next_count[tpss_pkg::DECIM_W-1:0];
            if (decim_count == '0 && gate_angle > cfg.min_angle) gate_angle = gate_angle - 1'b1;
         end
      end
      r.upper_gate = latched | upper_ch.pulsing;
      r.lower_gate = latched | lower_ch.pulsing;
      r.fully_on   = latched;
      r.angle_now  = gate_angle;
      return r;
   endfunction

   task automatic send_tick(input tick_type t);
      int unsigned gap;
      if ($urandom_range(0, 39) == 0) req_steady = !req_steady;
      gap = req_steady ? 0 : $urandom_range(0, 15);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= tpss_pkg::REQ_DATA_W'(t);
      do @(posedge clock); while (!req_tready);
      gate_drive_q.push_back(fire_tick(t));
      ticks_sent++;
   endtask

   task automatic wait_drained;
      req_tvalid <= 1'b0;
      while (gate_drive_q.size() != 0) @(posedge clock);
   endtask

   task automatic load_settings(input settings_type s);
      csr_we    <= 1'b1;
      csr_index <= tpss_pkg::CSR_INITIAL_ANGLE;
      csr_wdata <= tpss_pkg::CSR_DATA_W'(s.initial_angle);
      @(posedge clock);
      csr_index <= tpss_pkg::CSR_MIN_ANGLE;
      csr_wdata <= tpss_pkg::CSR_DATA_W'(s.min_angle);
      @(posedge clock);
      csr_index <= tpss_pkg::CSR_PULSE_TICKS;
      csr_wdata <= tpss_pkg::CSR_DATA_W'(s.pulse_ticks);
      @(posedge clock);
      csr_index <= tpss_pkg::CSR_DECIMATION;
      csr_wdata <= tpss_pkg::CSR_DATA_W'(s.decimation);
      @(posedge clock);
      csr_index <= tpss_pkg::CSR_START_THRESHOLD;
      csr_wdata <= tpss_pkg::CSR_DATA_W'(s.start_threshold);
      @(posedge clock);
      // writes past the register list must be dropped
      csr_index <= tpss_pkg::CSR_IDX_W'($urandom_range(CSR_SPARE_FIRST, CSR_SPARE_LAST));
      csr_wdata <= tpss_pkg::CSR_DATA_W'($urandom);
      @(posedge clock);
      csr_we <= 1'b0;
      cfg = s;
   endtask

   // half waves of random length, mostly clean zero crossings with some noise
   task automatic run_half_waves(input int unsigned count, input int unsigned slow_odds);
      tick_type    t;
      int unsigned sent;
      int unsigned len;
      int unsigned pick;
      sent = 0;
      while (sent < count) begin
         len  = $urandom_range(1, int'(gate_angle) + int'(cfg.pulse_ticks) + 40);
         pick = $urandom_range(0, 9);
         for (int unsigned k = 0; k < len && sent < count; k++) begin
            t = make_tick(1'b0, 1'b0, $urandom_range(0, 3) < slow_odds,
                          tpss_pkg::LEVEL_W'($urandom));
            if (k == 0) begin
               if (pick < 8) begin
                  t.pos_zero_cross = pos_next;
                  t.neg_zero_cross = !pos_next;
                  pos_next = !pos_next;
               end else if (pick == 8) begin
                  t.pos_zero_cross = 1'b1;
                  t.neg_zero_cross = 1'b1;
               end
            end else if ($urandom_range(0, 99) == 0) begin
               t.pos_zero_cross = 1'($urandom);
               t.neg_zero_cross = 1'($urandom);
            end
            send_tick(t);
            sent++;
         end
      end
   endtask

   task automatic test_field_extremes;
      send_tick(make_tick(1'b0, 1'b0, 1'b0, '0));
      send_tick(make_tick(1'b1, 1'b1, 1'b0, LEVEL_MAX));
      send_tick(make_tick(1'b0, 1'b0, 1'b1, tpss_pkg::START_THRESHOLD_RST));
      send_tick(make_tick(1'b0, 1'b0, 1'b1, '0));
      send_tick(make_tick(1'b0, 1'b1, 1'b0, 24'hAAAAAA));
      send_tick(make_tick(1'b1, 1'b0, 1'b1, 24'h555555));
      wait_drained();
   endtask

   task automatic test_soft_start_ramp;
      settings_type s;
      // angle floor 200, single tick pulses
      s = '{tpss_pkg::ANGLE_W'($urandom), 10'd200, 8'd0, 8'd1, LEVEL_MAX};
      load_settings(s);
      run_half_waves(PHASE_TICKS, 2);
      wait_drained();
      // angle held, longest pulses, decimate count left high
      s = '{tpss_pkg::ANGLE_W'($urandom), 10'd1023, 8'd255, 8'd200, LEVEL_MAX};
      load_settings(s);
      run_half_waves(PHASE_TICKS, 2);
      wait_drained();
      // decimation dropped below the running count
      s = '{tpss_pkg::ANGLE_W'($urandom), 10'd30, 8'd12, 8'd1, LEVEL_MAX};
      load_settings(s);
      run_half_waves(PHASE_TICKS, 2);
      wait_drained();
      // zero decimation, long pulses over short half waves
      s = '{tpss_pkg::ANGLE_W'($urandom), 10'd0, 8'd255, 8'd0, LEVEL_MAX};
      load_settings(s);
      run_half_waves(PHASE_TICKS, 3);
      wait_drained();
      s = '{tpss_pkg::ANGLE_W'($urandom), 10'd0, tpss_pkg::PULSE_W'($urandom), 8'd1,
            LEVEL_MAX};
      load_settings(s);
      run_half_waves(PHASE_TICKS, 4);
      wait_drained();
   endtask

   task automatic test_backpressure;
      req_steady = 1'b1;
      rsp_hold   = STALL_CYCLES;
      run_half_waves(60, 1);
      wait_drained();
   endtask

   task automatic test_latch_on;
      settings_type s;
      s = cfg;
      s.start_threshold = '0;
      load_settings(s);
      send_tick(make_tick(1'b0, 1'b0, 1'b1, '0));
      send_tick(make_tick(1'b0, 1'b0, 1'b0, 24'd1));
      send_tick(make_tick(1'b1, 1'b0, 1'b1, 24'd1));
      send_tick(make_tick(1'b1, 1'b1, 1'b0, '0));
      send_tick(make_tick(1'b0, 1'b0, 1'b1, LEVEL_MAX));
      wait_drained();
      s.start_threshold = LEVEL_MAX;
      s.decimation      = 8'd1;
      load_settings(s);
      send_tick(make_tick(1'b0, 1'b1, 1'b1, '0));
      send_tick(make_tick(1'b1, 1'b0, 1'b1, LEVEL_MAX));
      wait_drained();
   endtask

   // result sink with random stalls and one long hold-off on request
   initial begin
      int unsigned gap;
      wait (reset == 1'b0);
      forever begin
         if (rsp_hold != 0) begin
            rsp_tready <= 1'b0;
            repeat (rsp_hold) @(posedge clock);
            rsp_hold = 0;
         end
         if ($urandom_range(0, 39) == 0) rsp_steady = !rsp_steady;
         gap = rsp_steady ? 0 : $urandom_range(0, 15);
         if (gap != 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!(rsp_tvalid && rsp_tready));
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         got_drive = rsp_tdata[tpss_pkg::RSP_FIELD_W-1:0];
         if (gate_drive_q.size() == 0) begin
            $error("gate drive transaction with nothing expected");
            mismatches++;
         end else begin
            want_drive = gate_drive_q.pop_front();
            drives_checked++;
            if (got_drive.upper_gate !== want_drive.upper_gate) begin
               $error("upper_gate: expected %0d, got %0d",
                      want_drive.upper_gate, got_drive.upper_gate);
               mismatches++;
            end
            if (got_drive.lower_gate !== want_drive.lower_gate) begin
               $error("lower_gate: expected %0d, got %0d",
                      want_drive.lower_gate, got_drive.lower_gate);
               mismatches++;
            end
            if (got_drive.fully_on !== want_drive.fully_on) begin
               $error("fully_on: expected %0d, got %0d",
                      want_drive.fully_on, got_drive.fully_on);
               mismatches++;
            end
            if (got_drive.angle_now !== want_drive.angle_now) begin
               $error("angle_now: expected %0d, got %0d",
                      want_drive.angle_now, got_drive.angle_now);
               mismatches++;
            end
         end
      end
   end

   initial begin
      cfg = '{tpss_pkg::INITIAL_ANGLE_RST, tpss_pkg::MIN_ANGLE_RST, tpss_pkg::PULSE_TICKS_RST,
              tpss_pkg::DECIMATION_RST, tpss_pkg::START_THRESHOLD_RST};
      upper_ch    = '{1'b0, 1'b0, '0, '0};
      lower_ch    = '{1'b0, 1'b0, '0, '0};
      gate_angle  = tpss_pkg::INITIAL_ANGLE_RST;
      decim_count = '0;
      latched     = 1'b0;
      started     = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      test_field_extremes();
      test_soft_start_ramp();
      test_backpressure();
      test_latch_on();

      repeat (10) @(posedge clock);
      $display("checked %0d gate drive transactions over %0d ticks, %0d gate pulses fired",
               drives_checked, ticks_sent, pulses_fired);
      $display("firing angle ramped from %0d to %0d, then latch-on and its aftermath",
               tpss_pkg::INITIAL_ANGLE_RST, gate_angle);
      if (mismatches == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
